@@ rtl/core/dli_pkg.sv @@
// Package for the diffuse light intensity block.
// Holds widths, register map, payload structs and side-band types.
// No dependencies.
package dli_pkg;

	localparam int MAX_LEVELS = 256;
	localparam int LVL_W      = 9;
	localparam int COORD_W    = 32;
	localparam int NORM_W     = 16;
	localparam int DIFF_W     = COORD_W + 1;          // light - point
	localparam int SQ_W       = 2 * DIFF_W;           // one squared component
	localparam int SUMSQ_W    = SQ_W + 2;             // sum of three squares
	localparam int PROD_W     = DIFF_W + NORM_W;      // one d*n term
	localparam int DOT_W      = PROD_W + 2;           // sum of three terms
	localparam int T_W        = 60;                   // 4*levels*dot, dot > 0
	localparam int T_HALF     = T_W / 2;
	localparam int R_W        = 25;                   // result bits
	localparam int Q_W        = SUMSQ_W + R_W + 1;    // r*S
	localparam int P_W        = 122;                  // r^2*S and T^2
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	// register indexes (byte address = 4*index)
	localparam logic [1:0] REG_LIGHT_X    = 2'd0;
	localparam logic [1:0] REG_LIGHT_Y    = 2'd1;
	localparam logic [1:0] REG_LIGHT_Z    = 2'd2;
	localparam logic [1:0] REG_NUM_LEVELS = 2'd3;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic signed [NORM_W-1:0]  normal_x;
		logic signed [NORM_W-1:0]  normal_y;
		logic signed [NORM_W-1:0]  normal_z;
	} in_t;

	typedef struct packed {
		logic [R_W-1:0] intensity;
		logic           degenerate;
	} out_t;

	// carried alongside the root search
	typedef struct packed {
		logic           deg;
		logic [R_W-1:0] top;
	} side_t;

endpackage

@@ rtl/core/diffuse_light_intensity.sv @@
// Top level of the diffuse light intensity block: APB registers and front pipeline.
// Depends on dli_pkg and dli_search.
//
// Lambert diffuse term for a point light. One item is taken per cycle and passes through
// 6 front stages (difference, products, sums, scale, split square of the scaled dot),
// 25 stages of the root search (one result bit each) and the output register. The rate
// is one item per cycle; a stall on the output holds the whole pipeline, nothing is
// dropped. Registers should only be written while the pipeline is empty.
module diffuse_light_intensity (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  dli_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output dli_pkg::out_t                 out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dli_pkg::ADDR_W-1:0]    paddr,
	input  logic [dli_pkg::DATA_W-1:0]    pwdata,
	output logic [dli_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	// ---------------- registers
	logic signed [dli_pkg::COORD_W-1:0] light_x_q, light_y_q, light_z_q;
	logic [dli_pkg::LVL_W-1:0]          levels_q;
	logic [1:0]                         reg_idx;
	logic                               wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr      = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q <= '0;
			light_y_q <= '0;
			light_z_q <= '0;
			levels_q  <= '0;
		end else if (wr) begin
			case (reg_idx)
				dli_pkg::REG_LIGHT_X:    light_x_q <= pwdata;
				dli_pkg::REG_LIGHT_Y:    light_y_q <= pwdata;
				dli_pkg::REG_LIGHT_Z:    light_z_q <= pwdata;
				dli_pkg::REG_NUM_LEVELS: levels_q  <= pwdata[dli_pkg::LVL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			dli_pkg::REG_LIGHT_X:    prdata = light_x_q;
			dli_pkg::REG_LIGHT_Y:    prdata = light_y_q;
			dli_pkg::REG_LIGHT_Z:    prdata = light_z_q;
			dli_pkg::REG_NUM_LEVELS: prdata = dli_pkg::DATA_W'(levels_q);
			default:                 prdata = '0;
		endcase
	end

	// ---------------- pipeline control
	logic out_valid_q;
	logic en;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// ---------------- stage 1: differences, level saturation
	logic signed [dli_pkg::DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [dli_pkg::NORM_W-1:0] nx_s1, ny_s1, nz_s1;
	logic [dli_pkg::LVL_W-1:0]         lvl_s1;
	logic [dli_pkg::LVL_W-1:0]         lvl_sat;

	assign lvl_sat = (levels_q > dli_pkg::LVL_W'(dli_pkg::MAX_LEVELS))
		? dli_pkg::LVL_W'(dli_pkg::MAX_LEVELS) : levels_q;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= dli_pkg::DIFF_W'(light_x_q) - dli_pkg::DIFF_W'(in_data.point_x);
			dy_s1  <= dli_pkg::DIFF_W'(light_y_q) - dli_pkg::DIFF_W'(in_data.point_y);
			dz_s1  <= dli_pkg::DIFF_W'(light_z_q) - dli_pkg::DIFF_W'(in_data.point_z);
			nx_s1  <= in_data.normal_x;
			ny_s1  <= in_data.normal_y;
			nz_s1  <= in_data.normal_z;
			lvl_s1 <= lvl_sat;
		end
	end

	// ---------------- stage 2: squares and dot terms
	logic [dli_pkg::DIFF_W-1:0]        ax, ay, az;
	logic [dli_pkg::SQ_W-1:0]          sqx_s2, sqy_s2, sqz_s2;
	logic signed [dli_pkg::PROD_W-1:0] px_s2, py_s2, pz_s2;
	logic [dli_pkg::LVL_W-1:0]         lvl_s2;

	assign ax = dx_s1[dli_pkg::DIFF_W-1] ? dli_pkg::DIFF_W'(-dx_s1) : dx_s1;
	assign ay = dy_s1[dli_pkg::DIFF_W-1] ? dli_pkg::DIFF_W'(-dy_s1) : dy_s1;
	assign az = dz_s1[dli_pkg::DIFF_W-1] ? dli_pkg::DIFF_W'(-dz_s1) : dz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= dli_pkg::SQ_W'(ax) * dli_pkg::SQ_W'(ax);
			sqy_s2 <= dli_pkg::SQ_W'(ay) * dli_pkg::SQ_W'(ay);
			sqz_s2 <= dli_pkg::SQ_W'(az) * dli_pkg::SQ_W'(az);
			px_s2  <= dli_pkg::PROD_W'(dx_s1) * dli_pkg::PROD_W'(nx_s1);
			py_s2  <= dli_pkg::PROD_W'(dy_s1) * dli_pkg::PROD_W'(ny_s1);
			pz_s2  <= dli_pkg::PROD_W'(dz_s1) * dli_pkg::PROD_W'(nz_s1);
			lvl_s2 <= lvl_s1;
		end
	end

	// ---------------- stage 3: sums
	logic [dli_pkg::SUMSQ_W-1:0]      s_s3;
	logic signed [dli_pkg::DOT_W-1:0] dot_s3;
	logic [dli_pkg::LVL_W-1:0]        lvl_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s3   <= dli_pkg::SUMSQ_W'(sqx_s2) + dli_pkg::SUMSQ_W'(sqy_s2)
				+ dli_pkg::SUMSQ_W'(sqz_s2);
			dot_s3 <= dli_pkg::DOT_W'(px_s2) + dli_pkg::DOT_W'(py_s2)
				+ dli_pkg::DOT_W'(pz_s2);
			lvl_s3 <= lvl_s2;
		end
	end

	// ---------------- stage 4: T = 4*levels*dot for a positive dot
	logic                        dot_pos;
	logic [dli_pkg::T_W-1:0]     t_s4;
	logic [dli_pkg::SUMSQ_W-1:0] s_s4;
	dli_pkg::side_t              side_s4;

	assign dot_pos = !dot_s3[dli_pkg::DOT_W-1] && (dot_s3 != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s4 <= dot_pos
				? dli_pkg::T_W'(dli_pkg::T_W'({lvl_s3, 2'b00})
					* dli_pkg::T_W'(dot_s3[dli_pkg::DOT_W-2:0]))
				: '0;
			s_s4         <= s_s3;
			side_s4.deg  <= (s_s3 == '0);
			side_s4.top  <= dli_pkg::R_W'({lvl_s3, 16'h0000});
		end
	end

	// ---------------- stage 5: partial products of T^2
	logic [dli_pkg::T_W-1:0]     hh_s5, hl_s5, ll_s5;
	logic [dli_pkg::SUMSQ_W-1:0] s_s5;
	dli_pkg::side_t              side_s5;
	logic [dli_pkg::T_HALF-1:0]  th, tl;

	assign th = t_s4[dli_pkg::T_W-1:dli_pkg::T_HALF];
	assign tl = t_s4[dli_pkg::T_HALF-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s5   <= dli_pkg::T_W'(th) * dli_pkg::T_W'(th);
			hl_s5   <= dli_pkg::T_W'(th) * dli_pkg::T_W'(tl);
			ll_s5   <= dli_pkg::T_W'(tl) * dli_pkg::T_W'(tl);
			s_s5    <= s_s4;
			side_s5 <= side_s4;
		end
	end

	// ---------------- stage 6: T^2
	logic [dli_pkg::P_W-1:0]     t2_s6;
	logic [dli_pkg::SUMSQ_W-1:0] s_s6;
	dli_pkg::side_t              side_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			t2_s6 <= (dli_pkg::P_W'(hh_s5) << dli_pkg::T_W)
				+ (dli_pkg::P_W'(hl_s5) << (dli_pkg::T_HALF + 1))
				+ dli_pkg::P_W'(ll_s5);
			s_s6    <= s_s5;
			side_s6 <= side_s5;
		end
	end

	// ---------------- root search
	logic                    v_srch;
	logic [dli_pkg::R_W-1:0] r_srch;
	dli_pkg::side_t          side_srch;

	dli_search u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s6),
		.s_in     (s_s6),
		.t2_in    (t2_s6),
		.side_in  (side_s6),
		.v_out    (v_srch),
		.r_out    (r_srch),
		.side_out (side_srch)
	);

	// ---------------- output register
	dli_pkg::out_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_srch;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.degenerate <= side_srch.deg;
			if (side_srch.deg) begin
				out_q.intensity <= '0;
			end else begin
				out_q.intensity <= (r_srch < side_srch.top) ? r_srch : side_srch.top;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------- assertions
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |-> out_data.intensity == '0)
		else $error("degenerate result with nonzero intensity");

	a_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.intensity <= dli_pkg::R_W'(dli_pkg::MAX_LEVELS * 65536))
		else $error("intensity above full scale");

	a_lvl_wr: assert property (@(posedge clk) disable iff (!arst_n)
		wr && reg_idx == dli_pkg::REG_NUM_LEVELS
		|=> levels_q == $past(pwdata[dli_pkg::LVL_W-1:0]))
		else $error("level register write lost");

	a_t_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en && !dot_pos |=> t_s4 == '0)
		else $error("scaled dot nonzero for a nonpositive dot");

endmodule

@@ rtl/core/dli_search.sv @@
// Bit-per-stage search for the largest r with r^2*S <= T^2.
// Keeps r*S and r^2*S as running sums so each stage is shifts and adds.
// Depends on dli_pkg.
module dli_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          v_in,
	input  logic [dli_pkg::SUMSQ_W-1:0]   s_in,
	input  logic [dli_pkg::P_W-1:0]       t2_in,
	input  dli_pkg::side_t                side_in,
	output logic                          v_out,
	output logic [dli_pkg::R_W-1:0]       r_out,
	output dli_pkg::side_t                side_out
);

	localparam int N = dli_pkg::R_W;

	logic                        v_s    [N+1];
	logic [dli_pkg::SUMSQ_W-1:0] s_s    [N];
	logic [dli_pkg::P_W-1:0]     t2_s   [N];
	logic [dli_pkg::P_W-1:0]     p_s    [N];
	logic [dli_pkg::Q_W-1:0]     q_s    [N];
	logic [dli_pkg::R_W-1:0]     r_s    [N+1];
	dli_pkg::side_t              side_s [N+1];

	assign v_s[0]    = v_in;
	assign s_s[0]    = s_in;
	assign t2_s[0]   = t2_in;
	assign p_s[0]    = '0;
	assign q_s[0]    = '0;
	assign r_s[0]    = '0;
	assign side_s[0] = side_in;

	for (genvar j = 0; j < N; j++) begin : g_stage
		localparam int B = N - 1 - j;
		logic [dli_pkg::P_W-1:0] cand;
		logic                    fit;

		// (r + 2^B)^2 S = r^2 S + 2^(B+1) r S + 2^(2B) S
		assign cand = p_s[j] + (dli_pkg::P_W'(q_s[j]) << (B + 1))
			+ (dli_pkg::P_W'(s_s[j]) << (2 * B));
		assign fit = (cand <= t2_s[j]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[j+1] <= side_s[j];
				if (fit) begin
					r_s[j+1] <= r_s[j] | (dli_pkg::R_W'(1) << B);
				end else begin
					r_s[j+1] <= r_s[j];
				end
			end
		end

		// running sums are only needed by the stages that follow
		if (j < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					s_s[j+1]  <= s_s[j];
					t2_s[j+1] <= t2_s[j];
					if (fit) begin
						p_s[j+1] <= cand;
						q_s[j+1] <= q_s[j] + (dli_pkg::Q_W'(s_s[j]) << B);
					end else begin
						p_s[j+1] <= p_s[j];
						q_s[j+1] <= q_s[j];
					end
				end
			end
		end
	end

	assign v_out    = v_s[N];
	assign r_out    = r_s[N];
	assign side_out = side_s[N];

endmodule
